// ----- rtl/text_cell_cursor_editor_core_defines.svh -----
// ----------------------------------------------------------------------------
// Text cell cursor editor: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TEXT_CELL_CURSOR_EDITOR_CORE_DEFINES_SVH
`define TEXT_CELL_CURSOR_EDITOR_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define TCCE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define TCCE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tcce_pkg.sv -----
// ----------------------------------------------------------------------------
// Text cell cursor editor: package
// Geometry, field widths, request and key codes, state and memory types.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int ROWS   = 16;
  localparam int COLS   = 32;
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);

  localparam int REQ_W  = 2;
  localparam int KEY_W  = 8;
  localparam int ROW_W  = 4;
  localparam int COL_W  = 5;
  localparam int CHAR_W = 7;

  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLS - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

  localparam logic [REQ_W-1:0] REQ_KEY   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  localparam logic [KEY_W-1:0] KEY_UP     = 8'h5E;
  localparam logic [KEY_W-1:0] KEY_DOWN   = 8'h5F;
  localparam logic [KEY_W-1:0] KEY_LEFT   = 8'h3C;
  localparam logic [KEY_W-1:0] KEY_RIGHT  = 8'h3E;
  localparam logic [KEY_W-1:0] KEY_NL     = 8'h0A;
  localparam logic [KEY_W-1:0] KEY_BS     = 8'h08;
  localparam logic [KEY_W-1:0] PRINT_LOW  = 8'd32;
  localparam logic [KEY_W-1:0] PRINT_HIGH = 8'd126;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 7'h20;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_KEY,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_CLEAR,
    ST_DONE
  } tcce_state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } tcce_mem_req_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(int'(row) * COLS + int'(col));
  endfunction

  function automatic logic cell_in_range(input logic [ROW_W-1:0] row,
                                         input logic [COL_W-1:0] col);
    cell_in_range = (int'(row) < ROWS) && (int'(col) < COLS);
  endfunction

endpackage

// ----- rtl/tcce_req_if.sv -----
// ----------------------------------------------------------------------------
// Text cell cursor editor: request channel
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
interface tcce_req_if import tcce_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [KEY_W-1:0] key_code;
  logic [ROW_W-1:0] read_row;
  logic [COL_W-1:0] read_col;

  modport source (output valid, output req_type, output key_code,
                  output read_row, output read_col, input ready);
  modport sink   (input valid, input req_type, input key_code,
                  input read_row, input read_col, output ready);

endinterface

// ----- rtl/tcce_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Text cell cursor editor: response channel
// Valid/ready channel carrying one response word.
// ----------------------------------------------------------------------------
interface tcce_rsp_if import tcce_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;
  logic [CHAR_W-1:0] cell_char;
  logic              key_acted;

  modport source (output valid, output cursor_row, output cursor_col,
                  output cell_char, output key_acted, input ready);
  modport sink   (input valid, input cursor_row, input cursor_col,
                  input cell_char, input key_acted, output ready);

endinterface

// ----- rtl/tcce_store.sv -----
// ----------------------------------------------------------------------------
// Text cell cursor editor: cell store
// Single-write, single-read synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module tcce_store import tcce_pkg::*; (
  input  logic              clk,
  input  tcce_mem_req_t     mem_req,
  output logic [CHAR_W-1:0] rd_data_r
);

  logic [CHAR_W-1:0] mem_r [CELLS];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem_r[mem_req.waddr] <= mem_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[mem_req.raddr];
  end

endmodule

// ----- rtl/tcce_ctrl.sv -----
// ----------------------------------------------------------------------------
// Text cell cursor editor: control
// Request sequencer, cursor registers, clearing sweep and response register.
// ----------------------------------------------------------------------------
module tcce_ctrl import tcce_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  tcce_req_if.sink          in_req,
  tcce_rsp_if.source        out_rsp,
  output tcce_mem_req_t     mem_req,
  input  logic [CHAR_W-1:0] rd_data_r
);

  tcce_state_t       state_r, state_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [ROW_W-1:0]  rrow_r, rrow_nxt;
  logic [COL_W-1:0]  rcol_r, rcol_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              acted_r, acted_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_acted_r, out_acted_nxt;
  logic              slot_free;

  assign slot_free         = !out_valid_r || out_rsp.ready;
  assign in_req.ready      = (state_r == ST_IDLE);
  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.cursor_row = out_row_r;
  assign out_rsp.cursor_col = out_col_r;
  assign out_rsp.cell_char = out_char_r;
  assign out_rsp.key_acted = out_acted_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (cnt_r == LAST_ADDR) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_req.valid) begin
          case (in_req.req_type)
            REQ_KEY:   state_nxt = ST_KEY;
            REQ_CLEAR: state_nxt = ST_CLEAR;
            REQ_READ:  state_nxt = ST_RD_ADDR;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_KEY:     state_nxt = ST_DONE;
      ST_RD_ADDR: state_nxt = ST_RD_DATA;
      ST_RD_DATA: state_nxt = ST_DONE;
      ST_CLEAR: begin
        if (cnt_r == LAST_ADDR) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    row_nxt       = row_r;
    col_nxt       = col_r;
    key_nxt       = key_r;
    rrow_nxt      = rrow_r;
    rcol_nxt      = rcol_r;
    char_nxt      = char_r;
    acted_nxt     = acted_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_char_nxt  = out_char_r;
    out_acted_nxt = out_acted_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = cnt_r;
    mem_req.wdata = SPACE_CHAR;
    mem_req.raddr = cell_addr(rrow_r, rcol_r);
    case (state_r)
      ST_INIT, ST_CLEAR: begin
        // sweep spaces through every cell
        mem_req.we = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
      end
      ST_IDLE: begin
        if (in_req.valid) begin
          key_nxt   = in_req.key_code;
          rrow_nxt  = in_req.read_row;
          rcol_nxt  = in_req.read_col;
          char_nxt  = '0;
          acted_nxt = 1'b0;
          if (in_req.req_type == REQ_CLEAR) begin
            row_nxt = '0;
            col_nxt = '0;
            cnt_nxt = '0;
          end
        end
      end
      ST_KEY: begin
        acted_nxt = 1'b1;
        case (key_r)
          KEY_UP: begin
            if (row_r != '0) row_nxt = row_r - 1'b1;
          end
          KEY_DOWN: begin
            if (row_r != LAST_ROW) row_nxt = row_r + 1'b1;
          end
          KEY_LEFT: begin
            if (col_r != '0) begin
              col_nxt = col_r - 1'b1;
            end else if (row_r != '0) begin
              row_nxt = row_r - 1'b1;
              col_nxt = LAST_COL;
            end
          end
          KEY_RIGHT: begin
            if (col_r != LAST_COL) begin
              col_nxt = col_r + 1'b1;
            end else if (row_r != LAST_ROW) begin
              row_nxt = row_r + 1'b1;
              col_nxt = '0;
            end
          end
          KEY_NL: begin
            if (row_r != LAST_ROW) begin
              row_nxt = row_r + 1'b1;
              col_nxt = '0;
            end
          end
          KEY_BS: begin
            if (col_r != '0) begin
              col_nxt       = col_r - 1'b1;
              mem_req.we    = 1'b1;
              mem_req.waddr = cell_addr(row_r, col_r - 1'b1);
            end else if (row_r != '0) begin
              row_nxt       = row_r - 1'b1;
              col_nxt       = LAST_COL;
              mem_req.we    = 1'b1;
              mem_req.waddr = cell_addr(row_r - 1'b1, LAST_COL);
            end
          end
          default: begin
            if (key_r >= PRINT_LOW && key_r <= PRINT_HIGH) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = cell_addr(row_r, col_r);
              mem_req.wdata = key_r[CHAR_W-1:0];
              if (col_r != LAST_COL) begin
                col_nxt = col_r + 1'b1;
              end else if (row_r != LAST_ROW) begin
                row_nxt = row_r + 1'b1;
                col_nxt = '0;
              end
            end else begin
              acted_nxt = 1'b0;
            end
          end
        endcase
      end
      ST_RD_ADDR: begin
      end
      ST_RD_DATA: begin
        char_nxt = cell_in_range(rrow_r, rcol_r) ? rd_data_r : '0;
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = row_r;
          out_col_nxt   = col_r;
          out_char_nxt  = char_r;
          out_acted_nxt = acted_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      row_r       <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    rrow_r      <= rrow_nxt;
    rcol_r      <= rcol_nxt;
    char_r      <= char_nxt;
    acted_r     <= acted_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_char_r  <= out_char_nxt;
    out_acted_r <= out_acted_nxt;
  end

endmodule

// ----- rtl/text_cell_cursor_editor_core.sv -----
// ----------------------------------------------------------------------------
// Text cell cursor editor core
// Flow: a key request passes ST_KEY and ST_DONE, a read ST_RD_ADDR, ST_RD_DATA and
// ST_DONE, a clear ST_CLEAR (one cell a cycle) and ST_DONE, into the response register;
// one request at a time, so the next is taken only once ST_DONE has passed its word on.
// Reset: synchronous, active low; a sweep then fills every cell of the store with
// spaces while no request is taken, and the cursor sits at row 0, column 0.
// ----------------------------------------------------------------------------
`include "text_cell_cursor_editor_core_defines.svh"

module text_cell_cursor_editor_core import tcce_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tcce_req_if.sink   in_req,
  tcce_rsp_if.source out_rsp
);

  tcce_mem_req_t     mem_req;
  logic [CHAR_W-1:0] rd_data_r;

  tcce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .mem_req   (mem_req),
    .rd_data_r (rd_data_r)
  );

  tcce_store u_store (
    .clk       (clk),
    .mem_req   (mem_req),
    .rd_data_r (rd_data_r)
  );

  `TCCE_ASSERT_IMP(a_row_bound, out_rsp.valid, out_rsp.cursor_row <= LAST_ROW, "row out of range")
  `TCCE_ASSERT_IMP(a_col_bound, out_rsp.valid, out_rsp.cursor_col <= LAST_COL, "col out of range")
  `TCCE_ASSERT_NXT(a_one_req, in_req.valid && in_req.ready, !in_req.ready, "taken while busy")
  `TCCE_ASSERT_IMP(a_no_idle_write, mem_req.we, !in_req.ready, "store written while idle")

endmodule

// ----- tb/tb_text_cell_cursor_editor_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text cell cursor editor core: testbench
// Sends key, clear, read and unused request words and keeps a shadow copy of
// the cell store and cursor. Each response word is checked field by field
// against the shadow, in order. Directed corner cases run first, then random
// traffic under several idle and stall mixes, one long response hold-off and
// full drains between phases.
// ----------------------------------------------------------------------------
module tb_text_cell_cursor_editor_core;
  import tcce_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 8;
  localparam int PHASE_ITEMS    = 300;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [KEY_W-1:0] key_code;
    logic [ROW_W-1:0] read_row;
    logic [COL_W-1:0] read_col;
  } edit_req_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CHAR_W-1:0] cell_char;
    logic              key_acted;
  } edit_rsp_t;

  logic clk;
  logic rst_n;

  tcce_req_if in_req ();
  tcce_rsp_if out_rsp ();

  text_cell_cursor_editor_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  logic [CHAR_W-1:0] shadow_cells [CELLS];
  logic [ROW_W-1:0]  shadow_row;
  logic [COL_W-1:0]  shadow_col;
  edit_rsp_t         rsp_due [$];

  int unsigned mismatches      = 0;
  int unsigned req_idle_pct    = 0;
  int unsigned rsp_stall_pct   = 0;
  int unsigned hold_cycles_req = 0;
  int unsigned quiet_cycles    = 0;
  logic        rsp_hold;

  function automatic int cell_index(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    return int'(row) * COLS + int'(col);
  endfunction

  function automatic void home_and_blank();
    for (int i = 0; i < CELLS; i++) shadow_cells[i] = SPACE_CHAR;
    shadow_row = '0;
    shadow_col = '0;
  endfunction

  function automatic void step_forward();
    if (shadow_col != LAST_COL) begin
      shadow_col = shadow_col + 1'b1;
    end else if (shadow_row != LAST_ROW) begin
      shadow_row = shadow_row + 1'b1;
      shadow_col = '0;
    end
  endfunction

  function automatic logic step_back();
    if (shadow_col != '0) begin
      shadow_col = shadow_col - 1'b1;
      return 1'b1;
    end else if (shadow_row != '0) begin
      shadow_row = shadow_row - 1'b1;
      shadow_col = LAST_COL;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic edit_rsp_t predict_edit(input edit_req_t r);
    edit_rsp_t rsp;
    rsp = '0;
    case (r.req_type)
      REQ_KEY: begin
        rsp.key_acted = 1'b1;
        case (r.key_code)
          KEY_UP:    if (shadow_row != '0) shadow_row = shadow_row - 1'b1;
          KEY_DOWN:  if (shadow_row != LAST_ROW) shadow_row = shadow_row + 1'b1;
          KEY_LEFT:  void'(step_back());
          KEY_RIGHT: step_forward();
          KEY_NL: begin
            if (shadow_row != LAST_ROW) begin
              shadow_row = shadow_row + 1'b1;
              shadow_col = '0;
            end
          end
          KEY_BS: begin
            if (step_back()) shadow_cells[cell_index(shadow_row, shadow_col)] = SPACE_CHAR;
          end
          default: begin
            if (r.key_code >= PRINT_LOW && r.key_code <= PRINT_HIGH) begin
              shadow_cells[cell_index(shadow_row, shadow_col)] = r.key_code[CHAR_W-1:0];
              step_forward();
            end else begin
              rsp.key_acted = 1'b0;
            end
          end
        endcase
      end
      REQ_CLEAR: home_and_blank();
      REQ_READ: begin
        if (int'(r.read_row) < ROWS && int'(r.read_col) < COLS)
          rsp.cell_char = shadow_cells[cell_index(r.read_row, r.read_col)];
      end
      default: ;
    endcase
    rsp.cursor_row = shadow_row;
    rsp.cursor_col = shadow_col;
    return rsp;
  endfunction

  function automatic edit_req_t noise_req(input logic [REQ_W-1:0] kind);
    edit_req_t r;
    r.req_type = kind;
    r.key_code = KEY_W'($urandom);
    r.read_row = ROW_W'($urandom);
    r.read_col = COL_W'($urandom);
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_command();
    case ($urandom_range(5))
      0:       return KEY_UP;
      1:       return KEY_DOWN;
      2:       return KEY_LEFT;
      3:       return KEY_RIGHT;
      4:       return KEY_NL;
      default: return KEY_BS;
    endcase
  endfunction

  function automatic edit_req_t random_request();
    edit_req_t   r;
    int unsigned pick;
    r = noise_req(REQ_KEY);
    pick = $urandom_range(99);
    if (pick < 2) begin
      r.req_type = REQ_CLEAR;
    end else if (pick < 6) begin
      r.req_type = REQ_UNUSED;
    end else if (pick < 24) begin
      r.req_type = REQ_READ;
      if (pick < 15) r.read_row = shadow_row;
    end else if (pick < 54) begin
      r.key_code = pick_command();
    end else if (pick < 88) begin
      r.key_code = KEY_W'($urandom_range(PRINT_LOW, PRINT_HIGH));
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t: mismatch on %s, got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic send_req(input edit_req_t r);
    while ($urandom_range(99) < req_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid    <= 1'b1;
    in_req.req_type <= r.req_type;
    in_req.key_code <= r.key_code;
    in_req.read_row <= r.read_row;
    in_req.read_col <= r.read_col;
    do @(posedge clk); while (in_req.ready !== 1'b1);
    rsp_due.push_back(predict_edit(r));
  endtask

  task automatic send_key(input logic [KEY_W-1:0] code);
    edit_req_t r;
    r = noise_req(REQ_KEY);
    r.key_code = code;
    send_req(r);
  endtask

  task automatic send_read(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    edit_req_t r;
    r = noise_req(REQ_READ);
    r.read_row = row;
    r.read_col = col;
    send_req(r);
  endtask

  task automatic wait_for_results();
    in_req.valid <= 1'b0;
    do @(posedge clk); while (rsp_due.size() != 0);
  endtask

  task automatic test_clamped_and_ignored();
    send_key(KEY_UP);
    send_key(KEY_LEFT);
    send_key(KEY_BS);
    send_key(8'h00);
    send_key(8'h7F);
    send_key(8'h80);
    send_key(8'hFF);
    send_req(noise_req(REQ_UNUSED));
  endtask

  task automatic test_write_erase_read();
    send_key(PRINT_LOW);
    send_key(PRINT_HIGH);
    send_key(PRINT_HIGH);
    send_key(KEY_BS);
    send_read('0, COL_W'(1));
    send_read('0, COL_W'(2));
    send_key(KEY_NL);
  endtask

  task automatic test_last_cell();
    repeat (int'(LAST_ROW) - 1) send_key(KEY_DOWN);
    send_key(KEY_LEFT);
    send_key(KEY_DOWN);
    send_key(PRINT_HIGH);
    send_key(KEY_RIGHT);
    send_key(KEY_DOWN);
    send_key(KEY_NL);
    send_read(LAST_ROW, LAST_COL);
    send_req(noise_req(REQ_CLEAR));
    send_read(LAST_ROW, LAST_COL);
  endtask

  task automatic test_random_traffic(input int unsigned items, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    int unsigned      sent;
    int unsigned      run_len;
    logic [KEY_W-1:0] run_key;
    req_idle_pct  = idle_pct;
    rsp_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) == 0) begin
        run_key = pick_command();
        run_len = $urandom_range(8, 40);
        repeat (run_len) begin
          send_key(run_key);
          sent++;
        end
      end else begin
        send_req(random_request());
        sent++;
      end
    end
    wait_for_results();
  endtask

  task automatic test_backpressure();
    req_idle_pct    = 0;
    rsp_stall_pct   = 0;
    hold_cycles_req = HOLD_CYCLES;
    repeat (20) send_req(random_request());
    wait_for_results();
  endtask

  initial begin : clock_gen
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : rsp_hold_off
    rsp_hold <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles_req != 0) begin
        rsp_hold <= 1'b1;
        repeat (hold_cycles_req) @(posedge clk);
        rsp_hold <= 1'b0;
        hold_cycles_req = 0;
      end
    end
  end

  initial begin : rsp_check
    edit_rsp_t want;
    out_rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_rsp.valid && out_rsp.ready) begin
        if (rsp_due.size() == 0) begin
          report_mismatch("word with none due", out_rsp.cursor_row, 0);
        end else begin
          want = rsp_due.pop_front();
          if (out_rsp.cursor_row !== want.cursor_row)
            report_mismatch("cursor_row", out_rsp.cursor_row, want.cursor_row);
          if (out_rsp.cursor_col !== want.cursor_col)
            report_mismatch("cursor_col", out_rsp.cursor_col, want.cursor_col);
          if (out_rsp.cell_char !== want.cell_char)
            report_mismatch("cell_char", out_rsp.cell_char, want.cell_char);
          if (out_rsp.key_acted !== want.key_acted)
            report_mismatch("key_acted", out_rsp.key_acted, want.key_acted);
        end
      end
      out_rsp.ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    in_req.valid    <= 1'b0;
    in_req.req_type <= REQ_KEY;
    in_req.key_code <= '0;
    in_req.read_row <= '0;
    in_req.read_col <= '0;
    rst_n           <= 1'b0;
    home_and_blank();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_clamped_and_ignored();
    test_write_erase_read();
    test_last_cell();
    wait_for_results();
    test_random_traffic(PHASE_ITEMS, 0, 0);
    test_random_traffic(PHASE_ITEMS, 68, 0);
    test_backpressure();
    test_random_traffic(PHASE_ITEMS, 0, 68);
    test_random_traffic(PHASE_ITEMS, 13, 13);

    // hold for stray words after the last one due
    repeat (TAIL_CYCLES) @(posedge clk);
    if (rsp_due.size() != 0) report_mismatch("words never seen", rsp_due.size(), 0);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
